// ===== src/hamming_decoder_macros.svh =====
// Assertion macros used by the Hamming decoder checker.
`ifndef HAMMING_DECODER_MACROS_SVH
`define HAMMING_DECODER_MACROS_SVH

// Check a same-cycle implication, skipped while reset is high.
`define HD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check an implication in the next cycle, skipped while reset is high.
`define HD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/hd_pkg.sv =====
// Types, constants and decode tables for the Hamming decoder.
package hd_pkg;

  localparam int WORD_W  = 63;
  localparam int DATA_W  = 57;
  localparam int SYN_W   = 6;
  localparam int ORDER_W = 3;
  localparam int COUNT_W = 32;

  localparam logic [ORDER_W-1:0] ORDER_MIN   = 3'd2;
  localparam logic [ORDER_W-1:0] MAX_ORDER   = 3'd6;
  localparam logic [ORDER_W-1:0] ORDER_RESET = 3'd3;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;

  typedef logic [WORD_W-1:0]  word_t;
  typedef logic [DATA_W-1:0]  data_t;
  typedef logic [SYN_W-1:0]   syn_t;
  typedef logic [ORDER_W-1:0] order_t;
  typedef logic [COUNT_W-1:0] count_t;

  // Positions (bit index + 1) that carry bit j of their position number.
  function automatic word_t syn_mask(input int j);
    word_t mask;
    int    p;
    mask = '0;
    for (p = 1; p <= WORD_W; p++) begin
      mask[p-1] = p[j];
    end
    return mask;
  endfunction

  // Codeword bit index that holds data bit di (non-power-of-two positions).
  function automatic logic [SYN_W-1:0] data_pos(input int di);
    logic [SYN_W-1:0] idx;
    int               p;
    int               cnt;
    idx = '0;
    cnt = 0;
    for (p = 1; p <= WORD_W; p++) begin
      if ((p & (p - 1)) != 0) begin
        if (cnt == di) begin
          idx = SYN_W'(p - 1);
        end
        cnt++;
      end
    end
    return idx;
  endfunction

  // Valid positions of a codeword of order m.
  function automatic word_t len_mask(input order_t m);
    word_t mask;
    unique case (m)
      3'd2:    mask = 63'h7;
      3'd3:    mask = 63'h7F;
      3'd4:    mask = 63'h7FFF;
      3'd5:    mask = 63'h7FFF_FFFF;
      3'd6:    mask = '1;
      default: mask = 63'h7;
    endcase
    return mask;
  endfunction

endpackage

// ===== src/hamming_decoder.sv =====
// Hamming code decoder top level: input register, decode logic, result register.
// A request accepted at a clock edge enters the input register, then moves to the result register once it is free.
// Throughput: one codeword per cycle; the input stalls only while both stages hold a request
// and the result is stalled.
// The code_order write port is taken in any cycle and applies to the next request taken.
// Synchronous reset empties both stages, clears the count and sets code_order to 3.
module hamming_decoder
  import hd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [ORDER_W-1:0]  cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [WORD_W-1:0]   codeword,
  input  logic                last_word,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [DATA_W-1:0]   data_bits,
  output logic [SYN_W-1:0]    syndrome_value,
  output logic                was_corrected,
  output logic [COUNT_W-1:0]  corrected_total,
  output logic                last_out
);

  order_t code_order;
  order_t eff_order;
  logic   s1_valid;
  word_t  s1_word;
  logic   s1_last;
  logic   s1_load;
  logic   s2_load;
  count_t correction_count;
  count_t total_next;
  count_t correction_count_next;
  syn_t   syn;
  word_t  fixed_word;
  data_t  data_next;

  // Hold the configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      code_order <= ORDER_RESET;
    end else if (cfg_write) begin
      code_order <= cfg_data;
    end
  end

  // Clamp the order into the supported range.
  always_comb begin
    if (code_order < ORDER_MIN) begin
      eff_order = ORDER_MIN;
    end else if (code_order > MAX_ORDER) begin
      eff_order = MAX_ORDER;
    end else begin
      eff_order = code_order;
    end
  end

  // Advance stages when the next one is free.
  assign s2_load  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s2_load;
  assign s1_load  = in_valid && !in_stall;

  // Input stage: hold the masked word.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= 1'b1;
    end else if (s2_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_word <= codeword & len_mask(eff_order);
      s1_last <= last_word;
    end
  end

  // Compute syndrome, flip the named bit and gather data bits.
  always_comb begin
    for (int j = 0; j < SYN_W; j++) begin
      syn[j] = ^(s1_word & syn_mask(j));
    end
    if (syn != '0) begin
      fixed_word = s1_word ^ (word_t'(1) << 6'(syn - 6'd1));
    end else begin
      fixed_word = s1_word;
    end
    for (int di = 0; di < DATA_W; di++) begin
      data_next[di] = fixed_word[data_pos(di)];
    end
  end

  // Count corrected words, saturate, restart after the last word.
  always_comb begin
    if (syn != '0 && correction_count != COUNT_MAX) begin
      total_next = correction_count + count_t'(1);
    end else begin
      total_next = correction_count;
    end
    correction_count_next = s1_last ? '0 : total_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      correction_count <= '0;
    end else if (s2_load) begin
      correction_count <= correction_count_next;
    end
  end

  // Result stage: load on advance, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      data_bits       <= data_next;
      syndrome_value  <= syn;
      was_corrected   <= (syn != '0);
      corrected_total <= total_next;
      last_out        <= s1_last;
    end
  end

endmodule

// ===== src/hd_checker.sv =====
// Port-level checker for the Hamming decoder, bound to the top level.
`include "hamming_decoder_macros.svh"

module hd_checker
  import hd_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                cfg_write,
  input logic [ORDER_W-1:0]  cfg_data,
  input logic                in_valid,
  input logic                in_stall,
  input logic [WORD_W-1:0]   codeword,
  input logic                last_word,
  input logic                out_valid,
  input logic                out_stall,
  input logic [DATA_W-1:0]   data_bits,
  input logic [SYN_W-1:0]    syndrome_value,
  input logic                was_corrected,
  input logic [COUNT_W-1:0]  corrected_total,
  input logic                last_out
);

  // A stalled result holds its payload.
  `HD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(data_bits) && $stable(corrected_total) && $stable(syndrome_value), "stalled result changed")

  // The corrected flag follows the syndrome.
  `HD_ASSERT_NOW(a_flag_syn, out_valid, was_corrected == (syndrome_value != '0), "corrected flag does not match syndrome")

  // A corrected word is always counted.
  `HD_ASSERT_NOW(a_count_nonzero, out_valid && was_corrected, corrected_total != '0, "corrected word with zero total")

  // No result right after reset.
  `HD_ASSERT_NOW(a_reset_empty, $past(rst), !out_valid, "result valid right after reset")

endmodule

bind hamming_decoder hd_checker u_hd_checker (.*);
